// File: hw/rtl/olt_pkg.sv
// shared types, field widths and codes for the ordered list table
`timescale 1ns / 1ps

package olt_pkg;

    // field widths of one request and one result
    localparam int MODE_W   = 2;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 6;

    // request kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_ERASE  = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_MODIFY = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;   // capture an accepted request
        logic check;   // latch status and set up the walk
        logic step;    // one walk step over the list
        logic finish;  // load the result and commit the count
    } olt_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic req_err;    // request is refused
        logic walk_done;  // walk has issued its last access
        logic out_busy;   // result register still held
    } olt_sts_t;

endpackage

// File: hw/rtl/olt_req_if.sv
// request channel: valid/ready handshake with the request fields
`timescale 1ns / 1ps

interface olt_req_if;
    import olt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

// File: hw/rtl/olt_rsp_if.sv
// result channel: valid/ready handshake with the result fields
`timescale 1ns / 1ps

interface olt_rsp_if;
    import olt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [INDEX_W-1:0]  found_index;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output found, output found_index,
                    output count, input ready);
    modport sink   (input valid, input status, input found, input found_index,
                    input count, output ready);
endinterface

// File: hw/rtl/ordered_list_table.sv
// ordered list table: fixed-capacity list with insert, erase, find and modify
// a refused request skips the walk; insert walks from the count down to the position, erase
//   from the position to the end, modify writes one position, find scans up from index 0
// throughput: one request at a time, a held result delays the next one; the pace is
//   set by the one-entry-per-cycle walk through the list memory's single read and write ports
// reset: asynchronous active low; the count clears, memory contents are not cleared
`timescale 1ns / 1ps

module ordered_list_table #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input logic      clk,
    input logic      rst_n,
    olt_req_if.sink   req,
    olt_rsp_if.source rsp
);
    import olt_pkg::*;

    olt_cmd_t cmd;
    olt_sts_t sts;

    // sequencing
    olt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // list storage and result
    olt_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_mode        (req.mode),
        .req_position    (req.position),
        .req_value       (req.value),
        .cmd             (cmd),
        .sts             (sts),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_status      (rsp.status),
        .rsp_found       (rsp.found),
        .rsp_found_index (rsp.found_index),
        .rsp_count       (rsp.count)
    );

endmodule

// File: hw/rtl/olt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module olt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/olt_ctrl.sv
// controller state machine: request intake, walk sequencing, result hand-off
`timescale 1ns / 1ps

module olt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  olt_pkg::olt_sts_t sts,
    output olt_pkg::olt_cmd_t cmd
);
    import olt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CHECK;
                    ready_next = 1'b0;
                end
            end
            S_CHECK:
            begin
                state_next = sts.req_err ? S_DONE : S_WALK;
            end
            S_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    // command decode
    assign req_ready  = ready_reg;
    assign cmd.start  = ready_reg && req_valid;
    assign cmd.check  = (state_reg == S_CHECK);
    assign cmd.step   = (state_reg == S_WALK);
    assign cmd.finish = (state_reg == S_DONE) && !sts.out_busy;

    // ready is high only while waiting for a request
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg == (state_reg == S_IDLE))
        else $error("ready out of step with idle state");

    // an accepted request always goes to the check step
    a_start_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_CHECK) && !ready_reg)
        else $error("accepted request did not enter check");

    // a held result keeps the controller waiting
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && sts.out_busy |=> (state_reg == S_DONE))
        else $error("left done while result register was busy");

endmodule

// File: hw/rtl/olt_dp.sv
// datapath: request registers, list memory walk, count and result register
`timescale 1ns / 1ps

module olt_dp #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [olt_pkg::MODE_W-1:0]            req_mode,
    input  logic [olt_pkg::POS_W-1:0]             req_position,
    input  logic signed [olt_pkg::VALUE_W-1:0]    req_value,
    input  olt_pkg::olt_cmd_t                     cmd,
    output olt_pkg::olt_sts_t                     sts,
    input  logic                                  rsp_ready,
    output logic                                  rsp_valid,
    output logic [olt_pkg::STATUS_W-1:0]          rsp_status,
    output logic                                  rsp_found,
    output logic [olt_pkg::INDEX_W-1:0]           rsp_found_index,
    output logic [olt_pkg::COUNT_W-1:0]           rsp_count
);
    import olt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    // request registers
    mode_t                 mode_reg;
    logic [XW-1:0]         pos_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    status_t               st_reg;
    status_t               st_chk;

    // walk state
    logic [CW-1:0] count_reg;
    logic [XW-1:0] count_x;
    logic [XW-1:0] count_new_x;
    logic [XW-1:0] idx_reg, idx_next, idx_init, idx_inc, idx_dec;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          pend_word_reg, pend_word_next;
    logic          cmp_reg, cmp_next;
    logic [XW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          hit_reg;
    logic [XW-1:0] hit_idx_reg;
    logic [XW-1:0] rd_addr_x;
    logic [XW-1:0] pend_addr_x;
    logic          walk_done;

    // memory ports
    logic [63:0]           value_ext;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  cmp_hit;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_found_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    assign value_ext = {{(64 - VALUE_W){1'b0}}, $unsigned(req_value)};
    assign count_x   = XW'(count_reg);
    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;

    // refusal checks against the current count
    always_comb
    begin
        st_chk = ST_OK;
        case (mode_reg)
            MODE_INSERT:
            begin
                if (pos_reg > count_x)
                begin
                    st_chk = ST_RANGE;
                end
                else if (count_x >= CAP_X)
                begin
                    st_chk = ST_FULL;
                end
            end
            MODE_ERASE:
            begin
                if (count_x == '0)
                begin
                    st_chk = ST_EMPTY;
                end
                else if (pos_reg > count_x)
                begin
                    st_chk = ST_RANGE;
                end
            end
            MODE_FIND:
            begin
                st_chk = ST_OK;
            end
            MODE_MODIFY:
            begin
                if (pos_reg >= count_x)
                begin
                    st_chk = ST_RANGE;
                end
            end
            default:
            begin
                st_chk = ST_OK;
            end
        endcase
    end

    // start index of the walk
    always_comb
    begin
        case (mode_reg)
            MODE_INSERT: idx_init = count_x;
            MODE_FIND:   idx_init = '0;
            default:     idx_init = pos_reg;
        endcase
    end

    // one walk step: issue a read and queue the write or compare it feeds
    always_comb
    begin
        idx_next       = idx_reg;
        rd_addr_x      = '0;
        pend_next      = 1'b0;
        pend_addr_x    = '0;
        pend_word_next = 1'b0;
        cmp_next       = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        walk_done      = 1'b0;
        if (cmd.check)
        begin
            idx_next = idx_init;
        end
        else if (cmd.step)
        begin
            case (mode_reg)
                MODE_INSERT:
                begin
                    // move entries up from the top, then place the new word
                    if (idx_reg > pos_reg)
                    begin
                        rd_addr_x   = idx_dec;
                        pend_next   = 1'b1;
                        pend_addr_x = idx_reg;
                        idx_next    = idx_dec;
                    end
                    else
                    begin
                        pend_next      = 1'b1;
                        pend_addr_x    = pos_reg;
                        pend_word_next = 1'b1;
                        walk_done      = 1'b1;
                    end
                end
                MODE_ERASE:
                begin
                    // move entries down from the erased place
                    if (idx_reg < count_x - 1'b1)
                    begin
                        rd_addr_x   = idx_inc;
                        pend_next   = 1'b1;
                        pend_addr_x = idx_reg;
                        idx_next    = idx_inc;
                    end
                    else
                    begin
                        walk_done = 1'b1;
                    end
                end
                MODE_FIND:
                begin
                    // scan upward until a hit or the end of the list
                    if (hit_reg || (idx_reg >= count_x))
                    begin
                        walk_done = 1'b1;
                    end
                    else
                    begin
                        rd_addr_x    = idx_reg;
                        cmp_next     = 1'b1;
                        cmp_idx_next = idx_reg;
                        idx_next     = idx_inc;
                    end
                end
                MODE_MODIFY:
                begin
                    pend_next      = 1'b1;
                    pend_addr_x    = pos_reg;
                    pend_word_next = 1'b1;
                    walk_done      = 1'b1;
                end
                default:
                begin
                    walk_done = 1'b1;
                end
            endcase
        end
    end

    assign pend_addr_next = pend_addr_x[AW-1:0];
    assign ram_wdata      = pend_word_reg ? word_reg : ram_rdata;
    assign cmp_hit        = cmp_reg && !hit_reg && (ram_rdata == word_reg);

    // list storage
    olt_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (pend_reg),
        .waddr (pend_addr_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr_x[AW-1:0]),
        .rdata (ram_rdata)
    );

    // count after the request
    always_comb
    begin
        count_new_x = count_x;
        if (st_reg == ST_OK)
        begin
            case (mode_reg)
                MODE_INSERT: count_new_x = count_x + 1'b1;
                MODE_ERASE:  count_new_x = count_x - 1'b1;
                default:     count_new_x = count_x;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            cmp_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            cmp_reg  <= cmp_next;
            if (cmd.start)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmp_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                count_reg     <= count_new_x[CW-1:0];
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg    <= mode_t'(req_mode);
            pos_reg     <= XW'(req_position);
            word_reg    <= value_ext[DATA_WIDTH-1:0];
            hit_idx_reg <= '0;
        end
        else if (cmp_hit)
        begin
            hit_idx_reg <= cmp_idx_reg;
        end
        if (cmd.check)
        begin
            st_reg <= st_chk;
        end
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        pend_word_reg <= pend_word_next;
        cmp_idx_reg   <= cmp_idx_next;
        if (cmd.finish)
        begin
            out_status_reg <= st_reg;
            out_found_reg  <= hit_reg;
            out_index_reg  <= hit_idx_reg[INDEX_W-1:0];
            out_count_reg  <= count_new_x[COUNT_W-1:0];
        end
    end

    assign sts.req_err   = (st_chk != ST_OK);
    assign sts.walk_done = walk_done;
    assign sts.out_busy  = out_valid_reg && !rsp_ready;

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_found       = out_found_reg;
    assign rsp_found_index = out_index_reg;
    assign rsp_count       = out_count_reg;

    // the stored count never passes the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_x <= CAP_X)
        else $error("entry count above capacity");

    // memory writes stay inside the occupied part plus the slot being filled
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (XW'(pend_addr_reg) <= count_x))
        else $error("write beyond the list end");

    // a hit can only come from a find request
    a_hit_find: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_hit |-> (mode_reg == MODE_FIND) && $past(cmd.step))
        else $error("compare hit outside a find walk");

endmodule

// File: test/testbench.sv
// self-checking testbench for the ordered list table: directed and random requests
`timescale 1ns / 1ps

module testbench;
    import olt_pkg::*;

    localparam int     LIST_CAPACITY    = 32;
    localparam int     LIST_DATA_WIDTH  = 32;
    // longest walk through the list plus the fixed pipeline, with margin
    localparam int     SETTLE_CYCLES    = 2 * (LIST_CAPACITY + 7);
    localparam int     LONG_HOLD_CYCLES = 400;
    localparam int     MAX_REPORTS      = 100;
    localparam longint TIMEOUT_NS       = 64'd20_000_000;

    // one expected result
    typedef struct packed {
        status_t             status;
        logic                found;
        logic [INDEX_W-1:0]  found_index;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    // mode mixes for the random part
    typedef enum int {
        MIX_UNIFORM,
        MIX_GROW,
        MIX_SHRINK,
        MIX_LOOKUP
    } request_mix_t;

    logic clk;
    logic rst_n;

    olt_req_if req_if ();
    olt_rsp_if rsp_if ();

    ordered_list_table #(
        .CAPACITY   (LIST_CAPACITY),
        .DATA_WIDTH (LIST_DATA_WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the list contents and fill level
    logic [VALUE_W-1:0] shadow_list [LIST_CAPACITY];
    int                 shadow_count;
    list_result_t       pending_results [$];
    logic [VALUE_W-1:0] value_pool [6];

    int error_count;
    int burst_left;
    bit hold_rsp_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // count a mismatch, print the first ones
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // apply one request to the shadow list and give its result
    function automatic list_result_t compute_list_result(input mode_t kind,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic [VALUE_W-1:0] word);
        list_result_t r;
        int p;
        r        = '0;
        r.status = ST_OK;
        p        = pos;
        case (kind)
            MODE_INSERT:
            begin
                if (p > shadow_count)
                    r.status = ST_RANGE;
                else if (shadow_count >= LIST_CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = shadow_count; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = word;
                    shadow_count++;
                end
            end
            MODE_ERASE:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else if (p > shadow_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (int i = p; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
            end
            MODE_FIND:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_list[i] == word && !r.found)
                    begin
                        r.found       = 1'b1;
                        r.found_index = INDEX_W'(i);
                    end
                end
            end
            default:
            begin
                if (p >= shadow_count)
                    r.status = ST_RANGE;
                else
                    shadow_list[p] = word;
            end
        endcase
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    // position mostly in range, edges and noise now and then
    function automatic logic [POS_W-1:0] pick_position();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return POS_W'($urandom_range(0, 63));
            1:       return POS_W'(shadow_count);
            2:       return POS_W'(shadow_count + 1);
            default: return POS_W'($urandom_range(0, shadow_count));
        endcase
    endfunction

    // random word, a repeated word, or one already stored
    function automatic logic [VALUE_W-1:0] pick_value();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0 || (pick == 3 && shadow_count == 0))
            return $urandom;
        else if (pick == 3)
            return shadow_list[$urandom_range(0, shadow_count - 1)];
        else
            return value_pool[$urandom_range(0, 5)];
    endfunction

    // offer one request in bursts with gaps, predict it once taken
    task automatic send_request(input mode_t kind, input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] word);
        list_result_t res;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= kind;
        req_if.position <= pos;
        req_if.value    <= word;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        res = compute_list_result(kind, pos, word);
        pending_results.push_back(res);
        burst_left--;
    endtask

    // one random request drawn from a mode mix
    task automatic send_random_request(input request_mix_t mix);
        int    roll;
        int    ins_w;
        int    era_w;
        int    fnd_w;
        mode_t kind;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   begin ins_w = 55; era_w = 15; fnd_w = 15; end
            MIX_SHRINK: begin ins_w = 15; era_w = 55; fnd_w = 15; end
            MIX_LOOKUP: begin ins_w = 20; era_w = 20; fnd_w = 30; end
            default:    begin ins_w = 25; era_w = 25; fnd_w = 25; end
        endcase
        if (roll < ins_w)
            kind = MODE_INSERT;
        else if (roll < ins_w + era_w)
            kind = MODE_ERASE;
        else if (roll < ins_w + era_w + fnd_w)
            kind = MODE_FIND;
        else
            kind = MODE_MODIFY;
        if (kind == MODE_FIND)
            send_request(kind, POS_W'($urandom_range(0, 63)), pick_value());
        else
            send_request(kind, pick_position(), pick_value());
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_results_drained();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        burst_left = 0;
    endtask

    // corner cases on a short list
    task automatic test_directed();
        send_request(MODE_FIND,   6'd0,  32'h0000_0000);
        send_request(MODE_ERASE,  6'd0,  32'h0000_0000);
        send_request(MODE_ERASE,  6'd5,  32'h0000_0000);
        send_request(MODE_MODIFY, 6'd0,  32'h1234_5678);
        send_request(MODE_INSERT, 6'd1,  32'h1111_1111);
        send_request(MODE_INSERT, 6'd0,  32'h8000_0000);
        send_request(MODE_INSERT, 6'd0,  32'h7fff_ffff);
        send_request(MODE_INSERT, 6'd2,  32'h0000_0000);
        send_request(MODE_INSERT, 6'd1,  32'hffff_ffff);
        send_request(MODE_INSERT, 6'd63, 32'h2222_2222);
        send_request(MODE_FIND,   6'd63, 32'h8000_0000);
        send_request(MODE_FIND,   6'd0,  32'h0000_3039);
        send_request(MODE_MODIFY, 6'd3,  32'h0000_0007);
        send_request(MODE_MODIFY, 6'd4,  32'h0000_0008);
        send_request(MODE_MODIFY, 6'd63, 32'h0000_0009);
        send_request(MODE_FIND,   6'd0,  32'h0000_0007);
        // duplicate word: lowest index wins
        send_request(MODE_INSERT, 6'd0,  32'h8000_0000);
        send_request(MODE_FIND,   6'd0,  32'h8000_0000);
        // erase at count drops the last entry
        send_request(MODE_ERASE,  6'd5,  32'h0000_0000);
        send_request(MODE_ERASE,  6'd6,  32'h0000_0000);
        send_request(MODE_ERASE,  6'd0,  32'h0000_0000);
        send_request(MODE_ERASE,  6'd2,  32'h0000_0000);
        send_request(MODE_FIND,   6'd0,  32'h0000_0007);
    endtask

    // fill to capacity, poke at the full list, then drain to empty
    task automatic test_fill_drain(input int rounds);
        for (int n = 0; n < rounds; n++)
        begin
            while (shadow_count < LIST_CAPACITY)
            begin
                send_request(MODE_INSERT, POS_W'($urandom_range(0, shadow_count)), pick_value());
                if ($urandom_range(0, 7) == 0)
                    send_request(MODE_FIND, POS_W'($urandom), pick_value());
            end
            send_request(MODE_INSERT, POS_W'($urandom_range(0, LIST_CAPACITY)), pick_value());
            send_request(MODE_INSERT, POS_W'($urandom_range(LIST_CAPACITY + 1, 63)),
                         pick_value());
            send_request(MODE_FIND, POS_W'($urandom), shadow_list[LIST_CAPACITY - 1]);
            repeat (4)
                send_request(MODE_FIND, POS_W'($urandom), pick_value());
            repeat (3)
                send_request(MODE_MODIFY, pick_position(), pick_value());
            while (shadow_count > 0)
            begin
                send_request(MODE_ERASE, POS_W'($urandom_range(0, shadow_count)), pick_value());
                if ($urandom_range(0, 7) == 0)
                    send_request(MODE_FIND, POS_W'($urandom), pick_value());
            end
            send_request(MODE_ERASE, POS_W'($urandom_range(0, 63)), pick_value());
            send_request(MODE_MODIFY, POS_W'($urandom_range(0, 63)), pick_value());
            send_request(MODE_FIND, POS_W'($urandom_range(0, 63)), pick_value());
        end
    endtask

    // segments of random requests with changing mode mixes
    task automatic test_random_mix(input int num_items);
        request_mix_t mix;
        mix = MIX_UNIFORM;
        for (int n = 0; n < num_items; n++)
        begin
            if (n % 50 == 0)
                mix = request_mix_t'($urandom_range(0, 3));
            send_random_request(mix);
        end
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_rsp_req = 1'b1;
        burst_left   = 1000;
        repeat (40)
            send_random_request(MIX_UNIFORM);
        burst_left = 0;
    endtask

    // short runs with a full drain between them
    task automatic test_drain_pause();
        repeat (3)
        begin
            repeat (20)
                send_random_request(MIX_UNIFORM);
            wait_results_drained();
        end
    endtask

    // receiver: stall styles of random length, long hold on request
    initial
    begin : result_sink
        int style;
        int phase_left;
        style        = 0;
        phase_left   = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp_req)
            begin
                hold_rsp_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                if (phase_left <= 0)
                begin
                    style      = $urandom_range(0, 3);
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                case (style)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= ((phase_left % 16) < 8);
                endcase
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp_if.status, want.status));
                if (rsp_if.found !== want.found)
                    report_mismatch($sformatf("found got %0d want %0d",
                                              rsp_if.found, want.found));
                if (rsp_if.found_index !== want.found_index)
                    report_mismatch($sformatf("found_index got %0d want %0d",
                                              rsp_if.found_index, want.found_index));
                if (rsp_if.count !== want.count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              rsp_if.count, want.count));
            end
        end
    end

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.mode     = MODE_INSERT;
        req_if.position = '0;
        req_if.value    = '0;
        shadow_count    = 0;
        error_count     = 0;
        burst_left      = 0;
        hold_rsp_req    = 1'b0;
        value_pool[0]   = 32'h8000_0000;
        value_pool[1]   = 32'h7fff_ffff;
        value_pool[2]   = 32'h0000_0000;
        value_pool[3]   = 32'hffff_ffff;
        value_pool[4]   = 32'h0000_0001;
        value_pool[5]   = 32'h5a5a_5a5a;
        for (int i = 0; i < LIST_CAPACITY; i++)
            shadow_list[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_drain(3);
        test_random_mix(500);
        test_backpressure();
        test_drain_pause();
        test_random_mix(60);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: ordered_list_table.f
hw/rtl/olt_pkg.sv
hw/rtl/olt_req_if.sv
hw/rtl/olt_rsp_if.sv
hw/rtl/olt_ram.sv
hw/rtl/olt_ctrl.sv
hw/rtl/olt_dp.sv
hw/rtl/ordered_list_table.sv
test/testbench.sv
